### design/pidvd_pkg.sv
// ---------------------------------------------------------------------------
// pidvd_pkg: shared types and constants
// Register map, result codes, datapath commands and status for the PID loop.
// ---------------------------------------------------------------------------
package pidvd_pkg;

  localparam int unsigned Q_ONE_SEC = 1000;

  // serial divider geometry (derivative divide by dt only)
  localparam int unsigned DERIV_IT = 28;  // |diff*1000| < 2^27
  localparam int unsigned DIV_W    = DERIV_IT;
  localparam int unsigned DIV_IT_W = 5;
  localparam int unsigned DIVD_W   = 32;

  // integral step: divide by 125 through shift-and-fold passes
  localparam int unsigned DIV125_IT = 12;

  // register indexes
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_OUT_MIN   = 3'd3;
  localparam logic [2:0] REG_OUT_MAX   = 3'd4;
  localparam logic [2:0] REG_INT_LIMIT = 3'd5;

  // result status codes
  localparam logic [1:0] ST_COMPUTED = 2'd0;
  localparam logic [1:0] ST_FIRST    = 2'd1;
  localparam logic [1:0] ST_NO_DT    = 2'd2;

  typedef struct packed {
    logic        [15:0] gain_p;
    logic        [15:0] gain_i;
    logic        [15:0] gain_d;
    logic signed [15:0] out_min;
    logic signed [15:0] out_max;
    logic        [14:0] integral_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RECORD,
    OP_HOLD,
    OP_MUL_EDT,
    OP_DIV_I,
    OP_ACC,
    OP_MUL_P,
    OP_ADD8,
    OP_MUL_I,
    OP_ADD16,
    OP_MUL_K,
    OP_DIV_D,
    OP_MUL_D,
    OP_FINISH,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic not_started;
    logic no_dt;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

### design/pidvd_div.sv
// ---------------------------------------------------------------------------
// pidvd_div: serial restoring divider
// Unsigned, one quotient bit per cycle; dividend is left aligned by caller.
// ---------------------------------------------------------------------------
module pidvd_div import pidvd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [DIVD_W-1:0]   divisor,
  input  logic [DIV_IT_W-1:0] iters,
  output logic [DIV_W-1:0]    quo,
  output logic                done
);

  logic [DIV_W-1:0]    num_r;
  logic [DIVD_W-1:0]   den_r;
  logic [DIVD_W-1:0]   rem_r;
  logic [DIV_W-1:0]    quo_r;
  logic [DIV_IT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DIVD_W:0]     trial;
  logic [DIVD_W:0]     diff;
  logic                ge;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= dividend;
        den_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= iters;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
        num_r <= {num_r[DIV_W-2:0], 1'b0};
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

### design/pidvd_dp.sv
// ---------------------------------------------------------------------------
// pidvd_dp: PID datapath
// Loop state, shared multiplier, divider, accumulation and result register.
// ---------------------------------------------------------------------------
module pidvd_dp import pidvd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic signed [15:0] in_target,
  input  logic signed [15:0] in_measured,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_correction,
  output logic [1:0]         out_status
);

  // loop state
  logic signed [16:0] last_err_r;
  logic signed [31:0] accum_r;
  logic [31:0]        last_time_r;

  // per-word working registers
  logic signed [16:0] err_r;
  logic [31:0]        now_r;
  logic signed [50:0] prod_r;
  logic signed [39:0] total_r;
  logic               qneg_r;
  logic signed [15:0] res_corr_r;
  logic [1:0]         res_stat_r;

  logic               out_valid_r;
  logic signed [15:0] out_corr_r;
  logic [1:0]         out_stat_r;

  // divide by 125 unit: y = 125*q + r kept through every pass
  logic [52:0]        r125_r;
  logic [45:0]        q125_r;
  logic [3:0]         cnt125_r;
  logic               busy125_r;
  logic               done125_r;
  logic [45:0]        fold;
  logic [45:0]        q125;

  logic [31:0]        dt;
  logic signed [17:0] diff;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_ax;
  logic signed [50:0] mul_bx;
  logic signed [50:0] mul_p;
  logic signed [50:0] prod_abs;

  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic [DIVD_W-1:0]  div_den;
  logic [DIV_IT_W-1:0] div_it;
  logic [DIV_W-1:0]   div_q;
  logic               div_done;

  logic signed [49:0] q_int;
  logic signed [49:0] acc_sum;
  logic signed [49:0] lim;
  logic signed [49:0] acc_c;
  logic signed [28:0] deriv;
  logic signed [39:0] omin;
  logic signed [39:0] omax;
  logic signed [39:0] tot_c;

  assign dt   = now_r - last_time_r;
  assign diff = 18'(err_r) - 18'(last_err_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_EDT: begin
        mul_a = 18'(err_r);
        mul_b = {1'b0, dt};
      end
      OP_MUL_P: begin
        mul_a = {2'b00, cfg.gain_p};
        mul_b = 33'(err_r);
      end
      OP_MUL_I: begin
        mul_a = {2'b00, cfg.gain_i};
        mul_b = 33'(accum_r);
      end
      OP_MUL_K: begin
        mul_a = diff;
        mul_b = 33'(Q_ONE_SEC);
      end
      OP_MUL_D: begin
        mul_a = {2'b00, cfg.gain_d};
        mul_b = 33'(deriv);
      end
      default: ;
    endcase
  end

  assign mul_ax   = 51'(mul_a);
  assign mul_bx   = 51'(mul_b);
  assign mul_p    = mul_ax * mul_bx;
  assign prod_abs = prod_r[50] ? -prod_r : prod_r;

  // integral step |err*dt|*256/1000 = (|err*dt|*32)/125; each pass folds
  // r = 128*t + low into low + 3*t and adds t to the quotient
  assign fold = r125_r[52:7];
  assign q125 = (r125_r >= 53'd125) ? q125_r + 46'd1 : q125_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy125_r <= 1'b0;
      done125_r <= 1'b0;
      cnt125_r  <= '0;
    end else begin
      done125_r <= 1'b0;
      if (cmd.op == OP_DIV_I) begin
        r125_r    <= {prod_abs[47:0], 5'd0};
        q125_r    <= '0;
        cnt125_r  <= 4'(DIV125_IT);
        busy125_r <= 1'b1;
      end else if (busy125_r) begin
        r125_r   <= 53'(r125_r[6:0]) + 53'({fold, 1'b0}) + 53'(fold);
        q125_r   <= q125_r + fold;
        cnt125_r <= cnt125_r - 1'b1;
        if (cnt125_r == 4'd1) begin
          busy125_r <= 1'b0;
          done125_r <= 1'b1;
        end
      end
    end
  end

  // divider setup: derivative by dt
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_it    = '0;
    case (cmd.op)
      OP_DIV_D: begin
        div_start = 1'b1;
        div_num   = prod_abs[DIV_W-1:0];
        div_den   = dt;
        div_it    = DIV_IT_W'(DERIV_IT);
      end
      default: ;
    endcase
  end

  pidvd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .iters    (div_it),
    .quo      (div_q),
    .done     (div_done)
  );

  // integral update and clamp
  assign q_int   = qneg_r ? -50'(q125) : 50'(q125);
  assign acc_sum = 50'(accum_r) + q_int;
  assign lim     = 50'({1'b0, cfg.integral_limit, 8'd0});
  always_comb begin
    if (acc_sum > lim)       acc_c = lim;
    else if (acc_sum < -lim) acc_c = -lim;
    else                     acc_c = acc_sum;
  end

  assign deriv = qneg_r ? -{1'b0, div_q[DERIV_IT-1:0]} : {1'b0, div_q[DERIV_IT-1:0]};

  // output clamp, upper bound checked first
  assign omin = 40'(cfg.out_min);
  assign omax = 40'(cfg.out_max);
  always_comb begin
    if (total_r > omax)      tot_c = omax;
    else if (total_r < omin) tot_c = omin;
    else                     tot_c = total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      accum_r     <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          err_r <= 17'(in_target) - 17'(in_measured);
          now_r <= in_time_ms;
        end
        OP_RECORD: begin
          last_time_r <= now_r;
          res_corr_r  <= '0;
          res_stat_r  <= ST_FIRST;
        end
        OP_HOLD: begin
          res_corr_r <= '0;
          res_stat_r <= ST_NO_DT;
        end
        OP_MUL_EDT, OP_MUL_P, OP_MUL_I, OP_MUL_K, OP_MUL_D: prod_r <= mul_p;
        OP_DIV_I, OP_DIV_D: qneg_r <= prod_r[50];
        OP_ACC: begin
          accum_r <= acc_c[31:0];
          total_r <= '0;
        end
        OP_ADD8:  total_r <= total_r + 40'(prod_r >>> 8);
        OP_ADD16: total_r <= total_r + 40'(prod_r >>> 16);
        OP_FINISH: begin
          res_corr_r  <= tot_c[15:0];
          res_stat_r  <= ST_COMPUTED;
          last_err_r  <= err_r;
          last_time_r <= now_r;
        end
        OP_EMIT: begin
          out_corr_r <= res_corr_r;
          out_stat_r <= res_stat_r;
        end
        default: ;
      endcase
    end
  end

  assign stat.not_started = last_time_r == '0;
  assign stat.no_dt       = now_r == last_time_r;
  assign stat.div_done    = div_done || done125_r;
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_correction = out_corr_r;
  assign out_status     = out_stat_r;

endmodule

### design/pidvd_ctrl.sv
// ---------------------------------------------------------------------------
// pidvd_ctrl: PID sequencer
// Steps the datapath through one word: classify, integral, P, I, D, clamp.
// ---------------------------------------------------------------------------
module pidvd_ctrl import pidvd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MUL_EDT, S_DIVI, S_DIVI_WAIT, S_ACC,
    S_MUL_P, S_ADD_P, S_MUL_I, S_ADD_I, S_MUL_K, S_DIVD,
    S_DIVD_WAIT, S_MUL_D, S_ADD_D, S_FINISH, S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = OP_LOAD;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.not_started) begin
          cmd.op    = OP_RECORD;
          state_nxt = S_OUT;
        end else if (stat.no_dt) begin
          cmd.op    = OP_HOLD;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MUL_EDT;
        end
      end
      S_MUL_EDT: begin
        cmd.op    = OP_MUL_EDT;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.op    = OP_DIV_I;
        state_nxt = S_DIVI_WAIT;
      end
      S_DIVI_WAIT: if (stat.div_done) state_nxt = S_ACC;
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_ADD_P;
      end
      S_ADD_P: begin
        cmd.op    = OP_ADD8;
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.op    = OP_MUL_I;
        state_nxt = S_ADD_I;
      end
      S_ADD_I: begin
        cmd.op    = OP_ADD16;
        state_nxt = S_MUL_K;
      end
      S_MUL_K: begin
        cmd.op    = OP_MUL_K;
        state_nxt = S_DIVD;
      end
      S_DIVD: begin
        cmd.op    = OP_DIV_D;
        state_nxt = S_DIVD_WAIT;
      end
      S_DIVD_WAIT: if (stat.div_done) state_nxt = S_MUL_D;
      S_MUL_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = S_ADD_D;
      end
      S_ADD_D: begin
        cmd.op    = OP_ADD8;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.op    = OP_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: if (stat.out_free) begin
        cmd.op    = OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

### design/pid_loop_variable_dt_top.sv
// ---------------------------------------------------------------------------
// pid_loop_variable_dt_top: PID controller with variable sample interval
// Fixed-point PID with integral anti-windup and an APB register port.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) takes one word: target, measured,
//    time_ms. in_stall is high while a word is being worked on.
//  - Result channel (out_valid/out_stall) returns one word per input:
//    correction and status (computed, first sample, no time elapsed).
//  - Sequence: first-sample and no-time words go straight to the output
//    register. A computed word runs the integral step (scaling by 256/1000 as
//    12 shift-and-fold passes by 125), the derivative (28-step serial divide
//    by dt) and one shared 18x33 multiplier used five times.
//  - One word is worked on at a time; the next word is taken as soon as
//    the result sits in the output register, even if it is not yet taken.
//  - When the receiver stalls, the result holds in the output register and
//    the sequencer waits before loading the next result over it.
//  - Reset (rst_n low, synchronous) clears the loop state (not started,
//    integral and last error zero) and loads the register defaults.
//  - Registers at byte address 4*index; write only while idle.
// ---------------------------------------------------------------------------
module pid_loop_variable_dt_top import pidvd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_target,
  input  logic signed [15:0] in_measured,
  input  logic [31:0]        in_time_ms,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_correction,
  output logic [1:0]         out_status,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg_r;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register file; out of range indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.out_min        <= -16'sd12800;
      cfg_r.out_max        <= 16'sd12800;
      cfg_r.integral_limit <= 15'd6400;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN_P:    cfg_r.gain_p         <= pwdata[15:0];
        REG_GAIN_I:    cfg_r.gain_i         <= pwdata[15:0];
        REG_GAIN_D:    cfg_r.gain_d         <= pwdata[15:0];
        REG_OUT_MIN:   cfg_r.out_min        <= pwdata[15:0];
        REG_OUT_MAX:   cfg_r.out_max        <= pwdata[15:0];
        REG_INT_LIMIT: cfg_r.integral_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:    prdata = {16'd0, cfg_r.gain_p};
      REG_GAIN_I:    prdata = {16'd0, cfg_r.gain_i};
      REG_GAIN_D:    prdata = {16'd0, cfg_r.gain_d};
      REG_OUT_MIN:   prdata = 32'(cfg_r.out_min);
      REG_OUT_MAX:   prdata = 32'(cfg_r.out_max);
      REG_INT_LIMIT: prdata = {17'd0, cfg_r.integral_limit};
      default:       prdata = '0;
    endcase
  end

  pidvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pidvd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .stat           (stat),
    .in_target      (in_target),
    .in_measured    (in_measured),
    .in_time_ms     (in_time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_correction (out_correction),
    .out_status     (out_status)
  );

  // one word in flight: an accepted word blocks the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // uncomputed results carry zero
  a_zero_uncomputed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_COMPUTED |-> out_correction == 16'sd0)
    else $error("nonzero correction on uncomputed word");

  // computed results lie within ordered output limits
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_COMPUTED && cfg_r.out_min <= cfg_r.out_max
    |-> out_correction >= cfg_r.out_min && out_correction <= cfg_r.out_max)
    else $error("correction outside limits");

  // no result code beyond the defined ones
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_COMPUTED || out_status == ST_FIRST ||
                  out_status == ST_NO_DT)
    else $error("bad status code");

endmodule
